FILE: rtl/salim_pkg.sv
// shared types and constants for the stepper axis limit simulator
`default_nettype none
package salim_pkg;

  localparam int MAX_AXES       = 3;
  localparam int AXIS_COUNT_DEF = 3;
  localparam int POS_WIDTH_DEF  = 16;
  localparam int FIELD_W        = 16;
  localparam int MASK_W         = 8;
  localparam int WIDE_CFG_W     = 48;
  localparam int NARROW_CFG_W   = 24;
  localparam int CFG_ADDR_W     = 3;

  typedef enum logic [1:0] {
    REQ_READ_DATA   = 2'd0,
    REQ_WRITE_DATA  = 2'd1,
    REQ_READ_STATUS = 2'd2,
    REQ_READ_CTRL   = 2'd3
  } req_t;

  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_AXIS_LIMITS = 3'd0,
    CFG_AXIS_STARTS = 3'd1,
    CFG_STEP_MASKS  = 3'd2,
    CFG_DIR_MASKS   = 3'd3,
    CFG_STOP_BITS   = 3'd4
  } cfg_idx_t;

  // per-axis settings handed to each axis unit
  typedef struct packed {
    logic [MASK_W-1:0]  step_mask;
    logic [MASK_W-1:0]  dir_mask;
    logic [MASK_W-1:0]  stop_bits;
    logic [FIELD_W-1:0] limit;
    logic [FIELD_W-1:0] start;
  } axis_cfg_t;

endpackage
`default_nettype wire

FILE: rtl/salim_axis.sv
// one stepper axis: step edge detection, position counter and bound check
`default_nettype none
module salim_axis #(
  parameter int POSITION_WIDTH = salim_pkg::POS_WIDTH_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire salim_pkg::axis_cfg_t          cfg,
  input  wire logic                          reload,
  input  wire logic                          wr_en,
  input  wire logic [salim_pkg::MASK_W-1:0]  old_data,
  input  wire logic [salim_pkg::MASK_W-1:0]  new_data,
  output logic      [salim_pkg::MASK_W-1:0]  hit_bits
);

  logic [POSITION_WIDTH-1:0] pos_r;
  logic [POSITION_WIDTH-1:0] pos_nxt;
  logic [POSITION_WIDTH-1:0] start_pos;
  logic [POSITION_WIDTH-1:0] limit_pos;
  logic [salim_pkg::MASK_W-1:0] old_step;
  logic [salim_pkg::MASK_W-1:0] new_step;
  logic move;
  logic dir_up;

  // 16-bit fields sign-extend or truncate to the position width
  assign start_pos = POSITION_WIDTH'(signed'(cfg.start));
  assign limit_pos = POSITION_WIDTH'(signed'(cfg.limit));

  assign old_step = old_data & cfg.step_mask;
  assign new_step = new_data & cfg.step_mask;
  // step pulse ends: step bits changed and are now all low
  assign move     = wr_en && (old_step != new_step) && (new_step == '0);
  assign dir_up   = |(new_data & cfg.dir_mask);
  assign pos_nxt  = dir_up ? pos_r + POSITION_WIDTH'(1) : pos_r - POSITION_WIDTH'(1);

  always_comb begin
    hit_bits = '0;
    if (move && ((pos_nxt == '0) || (pos_nxt == limit_pos))) begin
      hit_bits = cfg.stop_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else if (reload) begin
      pos_r <= start_pos;
    end else if (move) begin
      pos_r <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/stepper_axis_limit_simulator.sv
// an accepted access goes first into the input reg, then into the result reg once that
// is free, and is offered on the output from the result reg
// throughput: one access per cycle, the input stage advances whenever the result reg frees
// a stalled result holds the input stage, which then drops in_ready
// reset (synchronous, active low) clears data, sticky status, settings and positions
// and empties both stages
`default_nettype none
module stepper_axis_limit_simulator #(
  parameter int AXIS_COUNT     = salim_pkg::AXIS_COUNT_DEF,
  parameter int POSITION_WIDTH = salim_pkg::POS_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_we,
  input  wire logic [salim_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [salim_pkg::WIDE_CFG_W-1:0]  cfg_wdata,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [1:0]                        in_req_type,
  input  wire logic [7:0]                        in_write_value,
  input  wire logic [7:0]                        in_write_mask,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic      [7:0]                        out_read_value
);

  localparam int MW = salim_pkg::MASK_W;
  localparam int FW = salim_pkg::FIELD_W;

  // settings
  logic [salim_pkg::WIDE_CFG_W-1:0]   axis_limits_r;
  logic [salim_pkg::WIDE_CFG_W-1:0]   axis_starts_r;
  logic [salim_pkg::NARROW_CFG_W-1:0] step_masks_r;
  logic [salim_pkg::NARROW_CFG_W-1:0] dir_masks_r;
  logic [salim_pkg::NARROW_CFG_W-1:0] stop_bits_r;
  logic                               reload;

  // input stage
  logic          in_vld_r;
  salim_pkg::req_t in_req_r;
  logic [MW-1:0] in_val_r;
  logic [MW-1:0] in_msk_r;

  // result stage
  logic          out_vld_r;
  logic [MW-1:0] out_data_r;
  logic [MW-1:0] out_data_nxt;

  logic [MW-1:0] data_r;
  logic [MW-1:0] data_nxt;
  logic [MW-1:0] status_r;
  logic [MW-1:0] status_nxt;

  logic          proc;
  logic          wr_en;
  logic [MW-1:0] new_data;
  logic [MW-1:0] hits;
  logic [MW-1:0] axis_hits [AXIS_COUNT];

  assign proc     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || proc;
  assign wr_en    = proc && (in_req_r == salim_pkg::REQ_WRITE_DATA);
  assign new_data = (data_r & ~in_msk_r) | (in_val_r & in_msk_r);
  assign reload   = cfg_we && (cfg_addr == salim_pkg::CFG_AXIS_STARTS);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      axis_limits_r <= '0;
      axis_starts_r <= '0;
      step_masks_r  <= '0;
      dir_masks_r   <= '0;
      stop_bits_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        salim_pkg::CFG_AXIS_LIMITS: axis_limits_r <= cfg_wdata;
        salim_pkg::CFG_AXIS_STARTS: axis_starts_r <= cfg_wdata;
        salim_pkg::CFG_STEP_MASKS:  step_masks_r  <= cfg_wdata[salim_pkg::NARROW_CFG_W-1:0];
        salim_pkg::CFG_DIR_MASKS:   dir_masks_r   <= cfg_wdata[salim_pkg::NARROW_CFG_W-1:0];
        salim_pkg::CFG_STOP_BITS:   stop_bits_r   <= cfg_wdata[salim_pkg::NARROW_CFG_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < AXIS_COUNT; i++) begin : g_axis
    salim_pkg::axis_cfg_t acfg;
    // a starts write reloads from the value being written
    assign acfg.step_mask  = step_masks_r[MW*i +: MW];
    assign acfg.dir_mask   = dir_masks_r[MW*i +: MW];
    assign acfg.stop_bits  = stop_bits_r[MW*i +: MW];
    assign acfg.limit      = axis_limits_r[FW*i +: FW];
    assign acfg.start      = cfg_wdata[FW*i +: FW];

    salim_axis #(
      .POSITION_WIDTH(POSITION_WIDTH)
    ) u_axis (
      .clk      (clk),
      .rst_n    (rst_n),
      .cfg      (acfg),
      .reload   (reload),
      .wr_en    (wr_en),
      .old_data (data_r),
      .new_data (new_data),
      .hit_bits (axis_hits[i])
    );
  end

  always_comb begin
    hits = '0;
    for (int i = 0; i < AXIS_COUNT; i++) begin
      hits = hits | axis_hits[i];
    end
  end

  always_comb begin
    data_nxt   = data_r;
    status_nxt = status_r;
    if (wr_en) begin
      data_nxt   = new_data;
      status_nxt = status_r | hits;
    end
    case (in_req_r)
      salim_pkg::REQ_READ_DATA:   out_data_nxt = data_r;
      salim_pkg::REQ_WRITE_DATA:  out_data_nxt = new_data;
      salim_pkg::REQ_READ_STATUS: out_data_nxt = status_r;
      default:                    out_data_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      data_r    <= '0;
      status_r  <= '0;
    end else begin
      data_r   <= data_nxt;
      status_r <= status_nxt;
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (proc) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_req_r <= salim_pkg::req_t'(in_req_type);
      in_val_r <= in_write_value;
      in_msk_r <= in_write_mask;
    end
    if (proc) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_read_value = out_data_r;

endmodule
`default_nettype wire

FILE: rtl/salim_checker.sv
// port-level checks for the stepper axis limit simulator, bound to the top level
`default_nettype none
module salim_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_read_value
);

  // a result waiting on the output keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_read_value))
    else $error("result changed while stalled");

  // both stages come out of reset empty
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("stage not empty after reset");

  // with the result reg free the input side never stalls
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // back-pressure only comes from a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without output back-pressure");

endmodule

bind stepper_axis_limit_simulator salim_checker u_salim_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_read_value (out_read_value)
);
`default_nettype wire

FILE: dv/tb.sv
// self-checking testbench for the stepper axis limit simulator: directed script then random
module tb;
  import salim_pkg::*;

  localparam int CYCLE_LIMIT     = 400_000;
  localparam int HOLD_CYCLES     = 300;
  localparam int ITEMS_PER_PHASE = 300;
  localparam int PHASES          = 6;
  localparam int SCRIPT_ROWS     = 28;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_NONE = 3'd7;
  localparam int FIRST_SPARE_IDX = int'(CFG_STOP_BITS) + 1;

  typedef enum logic {ROW_SETTING, ROW_ACCESS} row_kind_t;

  typedef struct packed {
    row_kind_t               kind;
    req_t                    req;
    logic [7:0]              val;
    logic [7:0]              mask;
    logic [CFG_ADDR_W-1:0]   idx;
    logic [WIDE_CFG_W-1:0]   data;
    logic                    known;
    logic [7:0]              want;
  } script_row_t;

  // reset settings first, then one pulse per axis, then all three axes at once
  localparam script_row_t PORT_SCRIPT [SCRIPT_ROWS] = '{
    '{ROW_ACCESS, REQ_READ_DATA, 8'h00, 8'h00, CFG_IDX_NONE, 48'h0, 1'b1, 8'h00},
    '{ROW_ACCESS, REQ_READ_STATUS, 8'hFF, 8'hFF, CFG_IDX_NONE, 48'h0, 1'b1, 8'h00},
    '{ROW_ACCESS, REQ_READ_CTRL, 8'hFF, 8'hFF, CFG_IDX_NONE, 48'h0, 1'b1, 8'h00},
    '{ROW_ACCESS, REQ_WRITE_DATA, 8'hFF, 8'hFF, CFG_IDX_NONE, 48'h0, 1'b1, 8'hFF},
    '{ROW_ACCESS, REQ_WRITE_DATA, 8'h00, 8'h00, CFG_IDX_NONE, 48'h0, 1'b1, 8'hFF},
    '{ROW_ACCESS, REQ_WRITE_DATA, 8'h00, 8'h0F, CFG_IDX_NONE, 48'h0, 1'b1, 8'hF0},
    '{ROW_ACCESS, REQ_WRITE_DATA, 8'h0F, 8'hF0, CFG_IDX_NONE, 48'h0, 1'b1, 8'h00},
    '{ROW_ACCESS, REQ_READ_CTRL, 8'h00, 8'h00, CFG_IDX_NONE, 48'h0, 1'b1, 8'h00},
    '{ROW_SETTING, REQ_READ_DATA, 8'h00, 8'h00, CFG_AXIS_LIMITS, 48'h8000_FFFF_0001,
      1'b0, 8'h00},
    '{ROW_SETTING, REQ_READ_DATA, 8'h00, 8'h00, CFG_AXIS_STARTS, 48'h7FFF_0000_0000,
      1'b0, 8'h00},
    '{ROW_SETTING, REQ_READ_DATA, 8'h00, 8'h00, CFG_STEP_MASKS, 48'hABCDEF_040201,
      1'b0, 8'h00},
    '{ROW_SETTING, REQ_READ_DATA, 8'h00, 8'h00, CFG_DIR_MASKS, 48'hFFFFFF_402010,
      1'b0, 8'h00},
    '{ROW_SETTING, REQ_READ_DATA, 8'h00, 8'h00, CFG_STOP_BITS, 48'h000000_040201,
      1'b0, 8'h00},
    '{ROW_SETTING, REQ_READ_DATA, 8'h00, 8'h00, CFG_IDX_NONE, 48'hFFFF_FFFF_FFFF,
      1'b0, 8'h00},
    '{ROW_ACCESS, REQ_WRITE_DATA, 8'h11, 8'hFF, CFG_IDX_NONE, 48'h0, 1'b1, 8'h11},
    '{ROW_ACCESS, REQ_WRITE_DATA, 8'h10, 8'hFF, CFG_IDX_NONE, 48'h0, 1'b1, 8'h10},
    '{ROW_ACCESS, REQ_READ_STATUS, 8'h00, 8'h00, CFG_IDX_NONE, 48'h0, 1'b1, 8'h01},
    '{ROW_ACCESS, REQ_WRITE_DATA, 8'h02, 8'h02, CFG_IDX_NONE, 48'h0, 1'b1, 8'h12},
    '{ROW_ACCESS, REQ_WRITE_DATA, 8'h00, 8'h32, CFG_IDX_NONE, 48'h0, 1'b1, 8'h00},
    '{ROW_ACCESS, REQ_READ_STATUS, 8'h00, 8'h00, CFG_IDX_NONE, 48'h0, 1'b1, 8'h03},
    '{ROW_ACCESS, REQ_WRITE_DATA, 8'h04, 8'hFF, CFG_IDX_NONE, 48'h0, 1'b1, 8'h04},
    '{ROW_ACCESS, REQ_WRITE_DATA, 8'h40, 8'hFF, CFG_IDX_NONE, 48'h0, 1'b1, 8'h40},
    '{ROW_ACCESS, REQ_WRITE_DATA, 8'h07, 8'hFF, CFG_IDX_NONE, 48'h0, 1'b1, 8'h07},
    '{ROW_ACCESS, REQ_WRITE_DATA, 8'h00, 8'hFF, CFG_IDX_NONE, 48'h0, 1'b0, 8'h00},
    '{ROW_ACCESS, REQ_WRITE_DATA, 8'h07, 8'hFF, CFG_IDX_NONE, 48'h0, 1'b0, 8'h00},
    '{ROW_ACCESS, REQ_WRITE_DATA, 8'h70, 8'hFF, CFG_IDX_NONE, 48'h0, 1'b0, 8'h00},
    '{ROW_ACCESS, REQ_READ_STATUS, 8'h00, 8'h00, CFG_IDX_NONE, 48'h0, 1'b0, 8'h00},
    '{ROW_ACCESS, REQ_READ_CTRL, 8'hA5, 8'h5A, CFG_IDX_NONE, 48'h0, 1'b1, 8'h00}
  };

  logic                    clk            = 1'b0;
  logic                    rst_n          = 1'b0;
  logic                    cfg_we         = 1'b0;
  logic [CFG_ADDR_W-1:0]   cfg_addr       = '0;
  logic [WIDE_CFG_W-1:0]   cfg_wdata      = '0;
  logic                    in_valid       = 1'b0;
  logic                    in_ready;
  req_t                    in_req_type    = REQ_READ_DATA;
  logic [7:0]              in_write_value = '0;
  logic [7:0]              in_write_mask  = '0;
  logic                    out_valid;
  logic                    out_ready      = 1'b0;
  logic [7:0]              out_read_value;

  stepper_axis_limit_simulator i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_req_type    (in_req_type),
    .in_write_value (in_write_value),
    .in_write_mask  (in_write_mask),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_read_value (out_read_value)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // port model state
  logic [7:0]              data_q;
  logic [7:0]              status_q;
  logic [15:0]             axis_pos_q [MAX_AXES];
  logic [WIDE_CFG_W-1:0]   axis_limits_q;
  logic [NARROW_CFG_W-1:0] step_masks_q;
  logic [NARROW_CFG_W-1:0] dir_masks_q;
  logic [NARROW_CFG_W-1:0] stop_bits_q;

  logic [7:0] read_values_due [$];

  int in_idle_pct     = 0;
  int out_stall_pct   = 0;
  int hold_asked      = 0;
  int holds_served    = 0;
  int hold_left       = 0;
  int errors          = 0;
  int accesses_sent   = 0;
  int results_checked = 0;
  int settings_written = 0;
  int cycle_count     = 0;

  initial begin
    data_q        = '0;
    status_q      = '0;
    axis_limits_q = '0;
    step_masks_q  = '0;
    dir_masks_q   = '0;
    stop_bits_q   = '0;
    foreach (axis_pos_q[a]) axis_pos_q[a] = '0;
  end

  function automatic logic [7:0] port_access(req_t req, logic [7:0] val, logic [7:0] mask);
    logic [7:0]  next_data;
    logic [7:0]  step;
    logic [7:0]  hits;
    logic [15:0] pos;
    hits = '0;
    case (req)
      REQ_WRITE_DATA: begin
        next_data = (data_q & ~mask) | (val & mask);
        for (int a = 0; a < MAX_AXES; a++) begin
          step = step_masks_q[8*a +: 8];
          // an axis steps when its step lines change and all end low
          if (((data_q & step) != (next_data & step)) && ((next_data & step) == 8'h00)) begin
            if ((next_data & dir_masks_q[8*a +: 8]) != 8'h00) pos = axis_pos_q[a] + 16'd1;
            else pos = axis_pos_q[a] - 16'd1;
            axis_pos_q[a] = pos;
            if (pos == 16'h0000 || pos == axis_limits_q[16*a +: 16])
              hits |= stop_bits_q[8*a +: 8];
          end
        end
        status_q |= hits;
        data_q = next_data;
        return data_q;
      end
      REQ_READ_DATA:   return data_q;
      REQ_READ_STATUS: return status_q;
      default:         return 8'h00;
    endcase
  endfunction

  function automatic void apply_setting(logic [CFG_ADDR_W-1:0] idx,
                                        logic [WIDE_CFG_W-1:0] value);
    case (idx)
      CFG_AXIS_LIMITS: axis_limits_q = value;
      CFG_AXIS_STARTS: begin
        for (int a = 0; a < MAX_AXES; a++) axis_pos_q[a] = value[16*a +: 16];
      end
      CFG_STEP_MASKS:  step_masks_q = value[NARROW_CFG_W-1:0];
      CFG_DIR_MASKS:   dir_masks_q = value[NARROW_CFG_W-1:0];
      CFG_STOP_BITS:   stop_bits_q = value[NARROW_CFG_W-1:0];
      default: ;
    endcase
  endfunction

  // write enable stays high until the next access lowers it
  task automatic write_setting(logic [CFG_ADDR_W-1:0] idx, logic [WIDE_CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    apply_setting(idx, value);
    settings_written++;
  endtask

  task automatic send_access(req_t req, logic [7:0] val, logic [7:0] mask,
                             logic known, logic [7:0] want);
    logic [7:0] predicted;
    cfg_we <= 1'b0;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_req_type    <= req;
    in_write_value <= val;
    in_write_mask  <= mask;
    do @(posedge clk); while (!in_ready);
    predicted = port_access(req, val, mask);
    read_values_due.push_back(known ? want : predicted);
    accesses_sent++;
  endtask

  // wait until every result is back and the pipeline is empty
  task automatic settle();
    in_valid <= 1'b0;
    while (read_values_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  always @(posedge clk) begin : result_check
    logic [7:0] due;
    if (out_valid && out_ready) begin
      if (read_values_due.size() == 0) begin
        errors++;
        $display("%0t: unexpected read value, expected none, got %02h", $time,
                 out_read_value);
      end else begin
        due = read_values_due.pop_front();
        results_checked++;
        if (due !== out_read_value) begin
          errors++;
          $display("%0t: read value mismatch, expected %02h, got %02h", $time, due,
                   out_read_value);
        end
      end
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (holds_served != hold_asked) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL stepper_axis_limit_simulator");
      $finish;
    end
  end

  initial begin : stimulus
    int          in_idle [4];
    int          out_stall [4];
    logic [WIDE_CFG_W-1:0]   starts;
    logic [WIDE_CFG_W-1:0]   limits;
    logic [NARROW_CFG_W-1:0] steps;
    logic [NARROW_CFG_W-1:0] dirs;
    logic [NARROW_CFG_W-1:0] lmasks;
    logic [15:0] s;
    logic [7:0]  step_all;
    logic [7:0]  val;
    logic [7:0]  mask;
    int          r;
    bit          in_flight;
    in_idle   = '{0, 50, 0, 16};
    out_stall = '{0, 0, 50, 16};
    in_flight = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (PORT_SCRIPT[i]) begin
      if (PORT_SCRIPT[i].kind == ROW_SETTING) begin
        if (in_flight) settle();
        in_flight = 1'b0;
        write_setting(PORT_SCRIPT[i].idx, PORT_SCRIPT[i].data);
      end else begin
        send_access(PORT_SCRIPT[i].req, PORT_SCRIPT[i].val, PORT_SCRIPT[i].mask,
                    PORT_SCRIPT[i].known, PORT_SCRIPT[i].want);
        in_flight = 1'b1;
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      settle();
      in_idle_pct   = in_idle[p % 4];
      out_stall_pct = out_stall[p % 4];
      for (int a = 0; a < MAX_AXES; a++) begin
        case ($urandom_range(4))
          0:       s = 16'h0000;
          1:       s = 16'hFFFF;
          2:       s = 16'h7FFF;
          3:       s = 16'h8000;
          default: s = 16'($urandom);
        endcase
        // limit a few steps either side of the start so bounds get hit
        starts[16*a +: 16] = s;
        limits[16*a +: 16] = s + 16'($urandom_range(6)) - 16'd3;
        steps[8*a +: 8]    = 8'(1 << $urandom_range(7)) | 8'(1 << $urandom_range(7));
        dirs[8*a +: 8]     = 8'($urandom);
        lmasks[8*a +: 8]   = 8'(1 << $urandom_range(7));
      end
      if (p == PHASES - 2) begin
        // no step lines at all: writes never move an axis
        steps  = '0;
        dirs   = '0;
        lmasks = '0;
        limits = '0;
        starts = '1;
      end else if (p == PHASES - 1) begin
        steps  = '1;
        dirs   = '1;
        lmasks = '1;
        limits = '1;
        starts = '0;
      end
      write_setting(CFG_AXIS_LIMITS, limits);
      write_setting(CFG_AXIS_STARTS, starts);
      write_setting(CFG_STEP_MASKS, {24'($urandom), steps});
      write_setting(CFG_DIR_MASKS, {24'($urandom), dirs});
      write_setting(CFG_STOP_BITS, {24'($urandom), lmasks});
      for (int idx = FIRST_SPARE_IDX; idx <= int'(CFG_IDX_NONE); idx++)
        write_setting(CFG_ADDR_W'(idx), {16'($urandom), $urandom});

      if (p == 0) hold_asked++;
      step_all = step_masks_q[7:0] | step_masks_q[15:8] | step_masks_q[23:16];
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        r    = $urandom_range(99);
        val  = 8'($urandom);
        mask = 8'($urandom);
        if (r < 30) send_access(REQ_WRITE_DATA, val, 8'hFF, 1'b0, 8'h00);
        else if (r < 55) send_access(REQ_WRITE_DATA, val, mask, 1'b0, 8'h00);
        else if (r < 75)
          // drop every step line so raised ones produce a step
          send_access(REQ_WRITE_DATA, val & ~step_all, mask | step_all, 1'b0, 8'h00);
        else send_access(req_t'($urandom_range(3)), val, mask, 1'b0, 8'h00);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("checked %0d read values from %0d bus accesses, %0d setting writes",
             results_checked, accesses_sent, settings_written);
    $display("idle mixes none/sender/receiver/both, one long receiver hold, status %02h",
             status_q);
    if (errors == 0) begin
      $display("PASS stepper_axis_limit_simulator");
    end else begin
      $display("FAIL stepper_axis_limit_simulator");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/salim_pkg.sv
rtl/salim_axis.sv
rtl/stepper_axis_limit_simulator.sv
rtl/salim_checker.sv
dv/tb.sv
